// ===== hw/rtl/csc_pkg.sv =====
package csc_pkg;

   localparam int COORD_WIDTH = 16;
   // Working width: the product of two coordinate differences needs about
   // twice the coordinate width before it is divided back down.
   localparam int CALC_WIDTH = 2 * COORD_WIDTH + 4;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int MAX_MOVES = 4;
   localparam int MOVE_CNT_WIDTH = $clog2(MAX_MOVES + 1);

   localparam logic [3:0] CODE_TOP    = 4'd8;
   localparam logic [3:0] CODE_BOTTOM = 4'd4;
   localparam logic [3:0] CODE_RIGHT  = 4'd2;
   localparam logic [3:0] CODE_LEFT   = 4'd1;

   localparam logic [1:0] STATUS_INSIDE   = 2'd0;
   localparam logic [1:0] STATUS_CLIPPED  = 2'd1;
   localparam logic [1:0] STATUS_REJECTED = 2'd2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WINDOW_LEFT   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WINDOW_RIGHT  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WINDOW_BOTTOM = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WINDOW_TOP    = 2'd3;

   localparam logic signed [COORD_WIDTH-1:0] RESET_WINDOW_LEFT   = COORD_WIDTH'(0);
   localparam logic signed [COORD_WIDTH-1:0] RESET_WINDOW_RIGHT  = COORD_WIDTH'(639);
   localparam logic signed [COORD_WIDTH-1:0] RESET_WINDOW_BOTTOM = COORD_WIDTH'(0);
   localparam logic signed [COORD_WIDTH-1:0] RESET_WINDOW_TOP    = COORD_WIDTH'(479);

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [CALC_WIDTH-1:0] calc_type;

   typedef struct packed {
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
   } req_type;

   typedef struct packed {
      logic [1:0] clip_status;
      coord_type  out_start_x;
      coord_type  out_start_y;
      coord_type  out_end_x;
      coord_type  out_end_y;
   } rsp_type;

endpackage

// ===== hw/rtl/cohen_sutherland_line_clipper.sv =====
// channel   ports                           direction  handshake
// request   start, busy, req_data           in         start && !busy
// result    rsp_valid, rsp_data             out        rsp_valid, one cycle
// config    csr_write_enable, csr_index,    in         csr_write_enable
//           csr_write_data
//
// A request trivially inside or rejected at once goes from acceptance through
// TEST to the result strobe; each endpoint move (at most four moves) adds an
// UPDATE, after a WAIT on the divider unless the divisor is zero.
// Such a move is set by the shared multiply/divide unit: one bit per cycle over
// the 36-bit working width for the product, then again for the quotient.
// Reset is synchronous: window returns to 0..639 by 0..479, no result pending.
// busy stays high from acceptance until the cycle the result strobes; the
// result is never held, so nothing stalls the block.
module cohen_sutherland_line_clipper (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  csc_pkg::req_type                        req_data,
   output logic                                    rsp_valid,
   output csc_pkg::rsp_type                        rsp_data,
   input  logic                                    csr_write_enable,
   input  logic [csc_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [csc_pkg::COORD_WIDTH-1:0]         csr_write_data
);
   import csc_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_TEST, ST_WAIT, ST_UPDATE} state_type;

   function automatic calc_type sext(input coord_type v);
      sext = {{(CALC_WIDTH - COORD_WIDTH){v[COORD_WIDTH-1]}}, v};
   endfunction

   state_type                 state_ff, state_in;
   coord_type                 left_ff, left_in;
   coord_type                 right_ff, right_in;
   coord_type                 bottom_ff, bottom_in;
   coord_type                 top_ff, top_in;
   calc_type                  x0_ff, x0_in, y0_ff, y0_in;
   calc_type                  x1_ff, x1_in, y1_ff, y1_in;
   logic [MOVE_CNT_WIDTH-1:0] moves_ff, moves_in;
   logic                      sel_ff, sel_in;
   logic                      vert_ff, vert_in;
   logic                      zero_div_ff, zero_div_in;
   calc_type                  edge_ff, edge_in;
   logic                      md_start_ff, md_start_in;
   calc_type                  md_a_ff, md_a_in, md_b_ff, md_b_in, md_c_ff, md_c_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;

   logic                      md_done;
   calc_type                  md_quot;

   // combinational view of the current endpoints
   logic [3:0]                code0, code1, code_pick;
   logic                      pick_end;
   logic                      pick_vert;
   calc_type                  edge_pick;
   calc_type                  px, py, ox, oy;
   calc_type                  delta_x, delta_y, to_edge;
   calc_type                  delta;

   function automatic logic [3:0] outcode(input calc_type x, input calc_type y,
                                          input coord_type wl, input coord_type wr,
                                          input coord_type wb, input coord_type wt);
      logic [3:0] c;
      c = 4'd0;
      if (y > sext(wt)) c = c | CODE_TOP;
      if (y < sext(wb)) c = c | CODE_BOTTOM;
      if (x > sext(wr)) c = c | CODE_RIGHT;
      if (x < sext(wl)) c = c | CODE_LEFT;
      outcode = c;
   endfunction

   csc_muldiv #(
      .WIDTH(CALC_WIDTH)
   ) u_muldiv (
      .clock (clock),
      .reset (reset),
      .start (md_start_ff),
      .op_a  (md_a_ff),
      .op_b  (md_b_ff),
      .op_c  (md_c_ff),
      .done  (md_done),
      .quot  (md_quot)
   );

   always_comb begin
      code0     = outcode(x0_ff, y0_ff, left_ff, right_ff, bottom_ff, top_ff);
      code1     = outcode(x1_ff, y1_ff, left_ff, right_ff, bottom_ff, top_ff);
      pick_end  = (code0 == 4'd0);
      code_pick = pick_end ? code1 : code0;
      pick_vert = |(code_pick & (CODE_TOP | CODE_BOTTOM));
      if (pick_vert) begin
         edge_pick = |(code_pick & CODE_TOP) ? sext(top_ff) : sext(bottom_ff);
      end else begin
         edge_pick = |(code_pick & CODE_RIGHT) ? sext(right_ff) : sext(left_ff);
      end
      px = pick_end ? x1_ff : x0_ff;
      py = pick_end ? y1_ff : y0_ff;
      ox = pick_end ? x0_ff : x1_ff;
      oy = pick_end ? y0_ff : y1_ff;
      delta_x = ox - px;
      delta_y = oy - py;
      to_edge = edge_pick - (pick_vert ? py : px);
      delta   = zero_div_ff ? '0 : md_quot;
   end

   always_comb begin
      state_in     = state_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      bottom_in    = bottom_ff;
      top_in       = top_ff;
      x0_in        = x0_ff;
      y0_in        = y0_ff;
      x1_in        = x1_ff;
      y1_in        = y1_ff;
      moves_in     = moves_ff;
      sel_in       = sel_ff;
      vert_in      = vert_ff;
      zero_div_in  = zero_div_ff;
      edge_in      = edge_ff;
      md_start_in  = 1'b0;
      md_a_in      = md_a_ff;
      md_b_in      = md_b_ff;
      md_c_in      = md_c_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_WINDOW_LEFT:   left_in   = csr_write_data;
            CSR_WINDOW_RIGHT:  right_in  = csr_write_data;
            CSR_WINDOW_BOTTOM: bottom_in = csr_write_data;
            CSR_WINDOW_TOP:    top_in    = csr_write_data;
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               x0_in    = sext(req_data.start_x);
               y0_in    = sext(req_data.start_y);
               x1_in    = sext(req_data.end_x);
               y1_in    = sext(req_data.end_y);
               moves_in = '0;
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            if ((code0 | code1) == 4'd0) begin
               rsp_in.clip_status = (moves_ff == '0) ? STATUS_INSIDE : STATUS_CLIPPED;
               rsp_in.out_start_x = x0_ff[COORD_WIDTH-1:0];
               rsp_in.out_start_y = y0_ff[COORD_WIDTH-1:0];
               rsp_in.out_end_x   = x1_ff[COORD_WIDTH-1:0];
               rsp_in.out_end_y   = y1_ff[COORD_WIDTH-1:0];
               rsp_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end else if ((code0 & code1) != 4'd0 ||
                         moves_ff == MOVE_CNT_WIDTH'(MAX_MOVES)) begin
               rsp_in.clip_status = STATUS_REJECTED;
               rsp_in.out_start_x = '0;
               rsp_in.out_start_y = '0;
               rsp_in.out_end_x   = '0;
               rsp_in.out_end_y   = '0;
               rsp_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end else begin
               sel_in  = pick_end;
               vert_in = pick_vert;
               edge_in = edge_pick;
               // moving along y: a = dx, c = dy; along x the roles swap
               md_a_in = pick_vert ? delta_x : delta_y;
               md_b_in = to_edge;
               md_c_in = pick_vert ? delta_y : delta_x;
               zero_div_in = pick_vert ? (delta_y == '0) : (delta_x == '0);
               if (zero_div_in) begin
                  state_in = ST_UPDATE;
               end else begin
                  md_start_in = 1'b1;
                  state_in    = ST_WAIT;
               end
            end
         end
         ST_WAIT: begin
            if (md_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (vert_ff) begin
               if (sel_ff) begin
                  x1_in = x1_ff + delta;
                  y1_in = edge_ff;
               end else begin
                  x0_in = x0_ff + delta;
                  y0_in = edge_ff;
               end
            end else begin
               if (sel_ff) begin
                  y1_in = y1_ff + delta;
                  x1_in = edge_ff;
               end else begin
                  y0_in = y0_ff + delta;
                  x0_in = edge_ff;
               end
            end
            moves_in = moves_ff + 1'b1;
            state_in = ST_TEST;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         left_ff      <= RESET_WINDOW_LEFT;
         right_ff     <= RESET_WINDOW_RIGHT;
         bottom_ff    <= RESET_WINDOW_BOTTOM;
         top_ff       <= RESET_WINDOW_TOP;
         moves_ff     <= '0;
         md_start_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         left_ff      <= left_in;
         right_ff     <= right_in;
         bottom_ff    <= bottom_in;
         top_ff       <= top_in;
         moves_ff     <= moves_in;
         md_start_ff  <= md_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x0_ff       <= x0_in;
      y0_ff       <= y0_in;
      x1_ff       <= x1_in;
      y1_ff       <= y1_in;
      sel_ff      <= sel_in;
      vert_ff     <= vert_in;
      zero_div_ff <= zero_div_in;
      edge_ff     <= edge_in;
      md_a_ff     <= md_a_in;
      md_b_ff     <= md_b_in;
      md_c_ff     <= md_c_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_rsp_when_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobed while a request is still in work");

   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_reject_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.clip_status == STATUS_REJECTED) |->
      (rsp_data.out_start_x == '0 && rsp_data.out_start_y == '0 &&
       rsp_data.out_end_x == '0 && rsp_data.out_end_y == '0))
      else $error("rejected segment carries nonzero coordinates");

   a_move_bound : assert property (@(posedge clock) disable iff (reset)
      moves_ff <= MOVE_CNT_WIDTH'(MAX_MOVES))
      else $error("endpoint move count past limit");

   a_md_idle_start : assert property (@(posedge clock) disable iff (reset)
      md_start_ff |-> (state_ff == ST_WAIT && $past(state_ff) == ST_TEST))
      else $error("divider started outside a move");
`endif

endmodule

// ===== hw/rtl/csc_muldiv.sv =====
module csc_muldiv #(
   parameter int WIDTH = csc_pkg::CALC_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [WIDTH-1:0] op_a,
   input  logic signed [WIDTH-1:0] op_b,
   input  logic signed [WIDTH-1:0] op_c,
   output logic                    done,
   output logic signed [WIDTH-1:0] quot
);
   import csc_pkg::*;

   // a * b / c, truncated toward zero. Shift-add multiply, then restoring
   // divide, both on one adder. The quotient must fit WIDTH bits.
   localparam int CNT_WIDTH = $clog2(WIDTH);

   typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV, MD_SIGN} md_state_type;

   md_state_type           state_ff, state_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic                   neg_ff, neg_in;
   logic [WIDTH-1:0]       ma_ff, ma_in;
   logic [WIDTH-1:0]       mc_ff, mc_in;
   logic [WIDTH:0]         hi_ff, hi_in;
   logic [WIDTH-1:0]       lo_ff, lo_in;
   logic signed [WIDTH-1:0] quot_ff, quot_in;
   logic                   done_ff, done_in;

   logic [WIDTH:0]         add_a;
   logic [WIDTH:0]         add_b;
   logic                   add_cin;
   logic [WIDTH+1:0]       sum_full;
   logic [WIDTH:0]         mul_pick;
   logic [WIDTH-1:0]       rem_next;

   always_comb begin
      add_a   = (state_ff == MD_MUL) ? hi_ff : {hi_ff[WIDTH-1:0], lo_ff[WIDTH-1]};
      add_b   = (state_ff == MD_MUL) ? {1'b0, ma_ff} : ~{1'b0, mc_ff};
      add_cin = (state_ff != MD_MUL);
      sum_full = {1'b0, add_a} + {1'b0, add_b} + {{(WIDTH + 1){1'b0}}, add_cin};
      mul_pick = lo_ff[0] ? sum_full[WIDTH:0] : hi_ff;
      // carry out of the subtract means partial remainder >= divisor
      rem_next = sum_full[WIDTH+1] ? sum_full[WIDTH-1:0] : add_a[WIDTH-1:0];
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      ma_in    = ma_ff;
      mc_in    = mc_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      quot_in  = quot_ff;
      done_in  = 1'b0;
      case (state_ff)
         MD_IDLE: begin
            if (start) begin
               neg_in   = op_a[WIDTH-1] ^ op_b[WIDTH-1] ^ op_c[WIDTH-1];
               ma_in    = op_a[WIDTH-1] ? WIDTH'(-op_a) : WIDTH'(op_a);
               lo_in    = op_b[WIDTH-1] ? WIDTH'(-op_b) : WIDTH'(op_b);
               mc_in    = op_c[WIDTH-1] ? WIDTH'(-op_c) : WIDTH'(op_c);
               hi_in    = '0;
               cnt_in   = CNT_WIDTH'(WIDTH - 1);
               state_in = MD_MUL;
            end
         end
         MD_MUL: begin
            hi_in = {1'b0, mul_pick[WIDTH:1]};
            lo_in = {mul_pick[0], lo_ff[WIDTH-1:1]};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               cnt_in   = CNT_WIDTH'(WIDTH - 1);
               state_in = MD_DIV;
            end
         end
         MD_DIV: begin
            hi_in  = {1'b0, rem_next};
            lo_in  = {lo_ff[WIDTH-2:0], sum_full[WIDTH+1]};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = MD_SIGN;
            end
         end
         MD_SIGN: begin
            quot_in  = neg_ff ? -$signed(lo_ff) : $signed(lo_ff);
            done_in  = 1'b1;
            state_in = MD_IDLE;
         end
         default: begin
            state_in = MD_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      ma_ff   <= ma_in;
      mc_ff   <= mc_in;
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// ===== tb/cohen_sutherland_line_clipper_tb.sv =====
module cohen_sutherland_line_clipper_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import csc_pkg::*;

   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int NUM_PHASES      = 9;
   localparam int ITEMS_PER_PHASE = 70;
   localparam int SETTLE_CYCLES   = 400;

   typedef logic signed [127:0] wide_type;

   typedef struct {
      req_type seg;
      bit      pinned;
      rsp_type want;
   } directed_row_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   req_type                    req_data = '0;
   logic                       rsp_valid;
   rsp_type                    rsp_data;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_WINDOW_LEFT;
   logic [COORD_WIDTH-1:0]     csr_write_data = '0;

   // typed-in expectation riding along with a directed request
   logic                       pin_valid = 1'b0;
   rsp_type                    pin_rsp = '0;

   longint                     win_left, win_right, win_bottom, win_top;
   rsp_type                    clip_results_due[$];
   rsp_type                    clip_want;
   directed_row_type           directed_rows[$];
   longint                     window_plan[NUM_PHASES][4];
   int                         error_count = 0;
   int                         cycle_count = 0;
   int                         burst_left = 0;
   bit                         gaps_on = 1'b1;

   cohen_sutherland_line_clipper DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #6 clock = ~clock;

   task automatic report_mismatch(string msg);
      $display("ERROR @%0d: %s", cycle_count, msg);
      error_count++;
   endtask

   task automatic check_field(string name, longint got, longint want);
      if (got != want) begin
         report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
      end
   endtask

   function automatic logic [3:0] region_code(longint x, longint y);
      logic [3:0] c;
      c = '0;
      if (y > win_top) c |= CODE_TOP;
      if (y < win_bottom) c |= CODE_BOTTOM;
      if (x > win_right) c |= CODE_RIGHT;
      if (x < win_left) c |= CODE_LEFT;
      return c;
   endfunction

   // a * b / c exactly, truncated toward zero
   function automatic longint scaled_offset(longint a, longint b, longint c);
      wide_type prod;
      prod = wide_type'(a) * wide_type'(b);
      return longint'(prod / wide_type'(c));
   endfunction

   function automatic rsp_type clip_segment(req_type r);
      longint     px[2], py[2];
      logic [3:0] code[2];
      longint     dx, dy, edge_v;
      int         moves, k;
      bit         done;
      logic [1:0] status;
      rsp_type    res;
      px[0] = r.start_x;
      py[0] = r.start_y;
      px[1] = r.end_x;
      py[1] = r.end_y;
      code[0] = region_code(px[0], py[0]);
      code[1] = region_code(px[1], py[1]);
      moves = 0;
      done = 1'b0;
      status = STATUS_INSIDE;
      if ((code[0] | code[1]) != 0) begin
         while (!done) begin
            if ((code[0] | code[1]) == 0) begin
               status = STATUS_CLIPPED;
               done = 1'b1;
            end else if ((code[0] & code[1]) != 0 || moves >= MAX_MOVES) begin
               status = STATUS_REJECTED;
               done = 1'b1;
            end else begin
               k = (code[0] != 0) ? 0 : 1;
               dx = px[1-k] - px[k];
               dy = py[1-k] - py[k];
               if ((code[k] & (CODE_TOP | CODE_BOTTOM)) != 0) begin
                  edge_v = ((code[k] & CODE_TOP) != 0) ? win_top : win_bottom;
                  if (dy != 0) px[k] = px[k] + scaled_offset(dx, edge_v - py[k], dy);
                  py[k] = edge_v;
               end else begin
                  edge_v = ((code[k] & CODE_RIGHT) != 0) ? win_right : win_left;
                  if (dx != 0) py[k] = py[k] + scaled_offset(dy, edge_v - px[k], dx);
                  px[k] = edge_v;
               end
               code[k] = region_code(px[k], py[k]);
               moves++;
            end
         end
      end
      res.clip_status = status;
      if (status == STATUS_REJECTED) begin
         res.out_start_x = '0;
         res.out_start_y = '0;
         res.out_end_x = '0;
         res.out_end_y = '0;
      end else begin
         res.out_start_x = coord_type'(px[0]);
         res.out_start_y = coord_type'(py[0]);
         res.out_end_x = coord_type'(px[1]);
         res.out_end_y = coord_type'(py[1]);
      end
      return res;
   endfunction

   // mostly in and around the window, some right at its edges, some anywhere
   function automatic coord_type pick_coord(longint lo, longint hi);
      longint a, b, v;
      a = (lo < hi) ? lo : hi;
      b = (lo < hi) ? hi : lo;
      case ($urandom_range(0, 7))
         0: return coord_type'($urandom);
         1, 2: begin
            v = ($urandom_range(0, 1) != 0) ? a : b;
            v = v + int'($urandom_range(0, 2)) - 1;
         end
         default: begin
            v = a - (b - a) / 2 - 32 + longint'($urandom_range(0, 2 * (b - a) + 64));
         end
      endcase
      if (v < -32768) v = -32768;
      if (v > 32767) v = 32767;
      return coord_type'(v);
   endfunction

   function automatic void add_row(int sx, int sy, int ex, int ey, bit pinned = 1'b0,
                                   logic [1:0] st = STATUS_INSIDE, int ox0 = 0,
                                   int oy0 = 0, int ox1 = 0, int oy1 = 0);
      directed_row_type row;
      row.seg.start_x = coord_type'(sx);
      row.seg.start_y = coord_type'(sy);
      row.seg.end_x = coord_type'(ex);
      row.seg.end_y = coord_type'(ey);
      row.pinned = pinned;
      row.want.clip_status = st;
      row.want.out_start_x = coord_type'(ox0);
      row.want.out_start_y = coord_type'(oy0);
      row.want.out_end_x = coord_type'(ox1);
      row.want.out_end_y = coord_type'(oy1);
      directed_rows.push_back(row);
   endfunction

   task automatic send_segment(req_type seg, bit pinned, rsp_type want);
      start <= 1'b1;
      req_data <= seg;
      pin_valid <= pinned;
      pin_rsp <= want;
      do @(posedge clock); while (busy);
   endtask

   // start stays high inside a burst, so back-to-back requests never toggle it
   task automatic pace_sender();
      if (burst_left > 0) burst_left--;
      if (gaps_on && burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 10);
      end
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (clip_results_due.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_WIDTH-1:0] idx, longint value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= coord_type'(value);
      @(posedge clock);
   endtask

   task automatic write_window(longint l, longint r, longint b, longint t);
      csr_write(CSR_WINDOW_LEFT, l);
      csr_write(CSR_WINDOW_RIGHT, r);
      csr_write(CSR_WINDOW_BOTTOM, b);
      csr_write(CSR_WINDOW_TOP, t);
      csr_write_enable <= 1'b0;
   endtask

   // result check first: a new request may be taken on the edge its predecessor retires
   always @(posedge clock) begin
      if (reset) begin
         win_left = RESET_WINDOW_LEFT;
         win_right = RESET_WINDOW_RIGHT;
         win_bottom = RESET_WINDOW_BOTTOM;
         win_top = RESET_WINDOW_TOP;
         clip_results_due.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_WINDOW_LEFT:   win_left = coord_type'(csr_write_data);
               CSR_WINDOW_RIGHT:  win_right = coord_type'(csr_write_data);
               CSR_WINDOW_BOTTOM: win_bottom = coord_type'(csr_write_data);
               CSR_WINDOW_TOP:    win_top = coord_type'(csr_write_data);
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (clip_results_due.size() == 0) begin
               report_mismatch("result strobe with no request outstanding");
            end else begin
               clip_want = clip_results_due.pop_front();
               check_field("clip_status", rsp_data.clip_status, clip_want.clip_status);
               check_field("out_start_x", rsp_data.out_start_x, clip_want.out_start_x);
               check_field("out_start_y", rsp_data.out_start_y, clip_want.out_start_y);
               check_field("out_end_x", rsp_data.out_end_x, clip_want.out_end_x);
               check_field("out_end_y", rsp_data.out_end_y, clip_want.out_end_y);
            end
         end
         if (start && !busy) begin
            clip_results_due.push_back(pin_valid ? pin_rsp : clip_segment(req_data));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         report_mismatch("timeout");
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int      p, n;
      req_type seg;
      rsp_type blank;
      blank = '0;

      // reset window 0..639 x 0..479
      add_row(10, 20, 600, 400, 1, STATUS_INSIDE, 10, 20, 600, 400);
      add_row(0, 0, 639, 479, 1, STATUS_INSIDE, 0, 0, 639, 479);
      add_row(639, 0, 0, 479, 1, STATUS_INSIDE, 639, 0, 0, 479);
      add_row(-100, -100, -50, -50, 1, STATUS_REJECTED);
      add_row(700, 100, 800, 200, 1, STATUS_REJECTED);
      add_row(100, 500, 200, 600, 1, STATUS_REJECTED);
      add_row(-32768, -32768, -32768, -32768, 1, STATUS_REJECTED);
      add_row(32767, 32767, 32767, 32767, 1, STATUS_REJECTED);
      add_row(-1, -1, -1, -1, 1, STATUS_REJECTED);
      add_row(640, 0, 640, 479, 1, STATUS_REJECTED);
      add_row(-10, 240, 650, 240, 1, STATUS_CLIPPED, 0, 240, 639, 240);
      add_row(320, -5, 320, 500, 1, STATUS_CLIPPED, 320, 0, 320, 479);
      add_row(-32768, -32768, 32767, 32767);
      add_row(32767, -32768, -32768, 32767);
      add_row(-20, -20, 20, 20);
      add_row(-50, 400, 100, 600);
      add_row(-10, 470, 20, 500);     // first move lands outside: rejected late
      add_row(-1000, -7, 700, 300);
      add_row(-32768, 32767, 0, 0);
      add_row(600, -3, 700, 100);
      add_row(-5, 479, -1, 480);
      add_row(639, 479, 640, 480);

      window_plan[0] = '{-32768, 32767, -32768, 32767};
      window_plan[1] = '{-100, 100, -50, 50};
      window_plan[2] = '{0, 0, 0, 0};
      window_plan[3] = '{200, -200, 150, -150};          // inverted
      window_plan[4] = '{32767, -32768, 32767, -32768};  // inverted, extremes
      window_plan[5] = '{-32768, -32768, 32767, 32767};
      window_plan[8] = '{0, 639, 0, 479};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_segment(directed_rows[i].seg, directed_rows[i].pinned, directed_rows[i].want);
         pace_sender();
      end
      drain_results();

      for (p = 0; p < NUM_PHASES; p++) begin
         if (p == 6) begin
            window_plan[6][0] = longint'(int'($urandom_range(0, 2000))) - 1000;
            window_plan[6][1] = window_plan[6][0] + int'($urandom_range(0, 800));
            window_plan[6][2] = longint'(int'($urandom_range(0, 2000))) - 1000;
            window_plan[6][3] = window_plan[6][2] + int'($urandom_range(0, 800));
         end else if (p == 7) begin
            for (int j = 0; j < 4; j++) window_plan[7][j] = coord_type'($urandom);
         end
         write_window(window_plan[p][0], window_plan[p][1], window_plan[p][2],
                      window_plan[p][3]);
         gaps_on = (p % 3 != 1);
         burst_left = 0;
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            seg.start_x = pick_coord(window_plan[p][0], window_plan[p][1]);
            seg.start_y = pick_coord(window_plan[p][2], window_plan[p][3]);
            seg.end_x = pick_coord(window_plan[p][0], window_plan[p][1]);
            seg.end_y = pick_coord(window_plan[p][2], window_plan[p][3]);
            send_segment(seg, 1'b0, blank);
            pace_sender();
            if (p == 2 && n == ITEMS_PER_PHASE / 2) drain_results();
         end
         drain_results();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (clip_results_due.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", clip_results_due.size()));
      end
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/csc_pkg.sv
hw/rtl/csc_muldiv.sv
hw/rtl/cohen_sutherland_line_clipper.sv
tb/cohen_sutherland_line_clipper_tb.sv
